@@ sv/asdd_pkg.sv @@
package asdd_pkg;

  localparam int COUNT_BITS_DEF = 16;
  localparam int LUMA_BITS_DEF  = 32;

  localparam int DIV_DVD_W  = 64;
  localparam int DIV_DSR_W  = 32;
  localparam int DIV_STEP_W = 7;

  localparam int LIMB_W    = 32;
  localparam int NUM_LIMBS = 5;
  localparam int WIDE_W    = LIMB_W * NUM_LIMBS;

  localparam int IN_DATA_W  = 32;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 120;

  localparam logic [15:0] MIN_SAMPLES_RST  = 16'd64;
  localparam logic [15:0] MAX_SAMPLES_RST  = 16'd2048;
  localparam logic        LIMIT_ENABLE_RST = 1'b1;
  localparam logic [15:0] MAX_ERROR_RST    = 16'd3277;
  localparam logic [15:0] QUANTILE_RST     = 16'd8028;
  localparam logic        PER_PIXEL_RST    = 1'b0;
  localparam logic [31:0] AVG_LUMA_RST     = 32'd65536;

  typedef enum logic [2:0] {
    REG_MIN_SAMPLES  = 3'd0,
    REG_MAX_SAMPLES  = 3'd1,
    REG_LIMIT_ENABLE = 3'd2,
    REG_MAX_ERROR    = 3'd3,
    REG_QUANTILE     = 3'd4,
    REG_PER_PIXEL    = 3'd5,
    REG_AVG_LUMA     = 3'd6
  } cfg_index_t;

  typedef enum logic [1:0] {
    REASON_NONE  = 2'd0,
    REASON_LIMIT = 2'd1,
    REASON_CONV  = 2'd2
  } reason_t;

  typedef enum logic [10:0] {
    ST_IDLE     = 11'b000_0000_0001,
    ST_PREP     = 11'b000_0000_0010,
    ST_DIV_MEAN = 11'b000_0000_0100,
    ST_SQ       = 11'b000_0000_1000,
    ST_ACC      = 11'b000_0001_0000,
    ST_DIV_VAR  = 11'b000_0010_0000,
    ST_DECIDE   = 11'b000_0100_0000,
    ST_MUL_LHS  = 11'b000_1000_0000,
    ST_MUL_RHS  = 11'b001_0000_0000,
    ST_CMP      = 11'b010_0000_0000,
    ST_OUT      = 11'b100_0000_0000
  } state_t;

  typedef struct packed {
    logic                  start;
    logic [DIV_STEP_W-1:0] steps;
    logic [DIV_DVD_W-1:0]  dividend;
    logic [DIV_DSR_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                 busy;
    logic                 done;
    logic [DIV_DVD_W-1:0] quotient;
  } div_rsp_t;

endpackage

@@ sv/adaptive_sample_stop_decider_unit.sv @@
// Channel   Direction  Handshake                      Contents
// s_axis    in         s_axis_tvalid / s_axis_tready  one luminance sample and its flags
// m_axis    out        m_axis_tvalid / m_axis_tready  stop decision and pixel statistics
// cfg       in         cfg_valid / cfg_ready          register index and write data
//
// s_axis_tready stays low while a sample is processed: the mean division,
// from the second sample of a pixel on the 64-step variance division, and,
// when it runs, the confidence test (nine factors, five limbs each).
// Reset clears the statistics and loads the register defaults; no sweep follows.
// An untaken result holds the unit in its final state; the next sample is
// accepted as soon as the result sits in the output register.
module adaptive_sample_stop_decider_unit #(
  parameter int COUNT_BITS = asdd_pkg::COUNT_BITS_DEF,
  parameter int LUMA_BITS  = asdd_pkg::LUMA_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // s_axis_tdata: luminance [31:0]
  input  logic [asdd_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // s_axis_tuser: sample_accepted [0], first_of_pixel [1]
  input  logic [asdd_pkg::IN_USER_W-1:0]   s_axis_tuser,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // m_axis_tdata: done_res [0], stop_reason [2:1], sample_count [18:3],
  // mean_out [50:19], variance_out [114:51], zero padding [119:115]
  output logic [asdd_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  asdd_pkg::cfg_index_t             cfg_index,
  input  logic [31:0]                      cfg_data
);
  import asdd_pkg::*;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  // Configuration registers.
  logic [15:0] min_samples;
  logic [15:0] max_samples;
  logic        limit_enable;
  logic [15:0] max_error;
  logic [15:0] quantile;
  logic        per_pixel;
  logic [31:0] avg_luma;

  // Pixel statistics.
  logic [31:0]           running_mean;
  logic [63:0]           m2;
  logic [COUNT_BITS-1:0] count;

  // Working registers for the sample in flight.
  state_t              state;
  logic [31:0]         x;
  logic                ge;
  logic [31:0]         d1;
  logic [63:0]         inc;
  logic [63:0]         variance;
  reason_t             reason;
  logic [WIDE_W-1:0]   acc;
  logic [WIDE_W-1:0]   lhs;
  logic [LIMB_W-1:0]   carry;
  logic [2:0]          limb;
  logic [2:0]          fstep;

  // Result register.
  logic                out_valid;
  logic [OUT_DATA_W-1:0] out_data;

  // Shared arithmetic.
  logic [31:0] n32;
  logic [31:0] ref_val;
  logic [31:0] mean_ge;
  logic [31:0] d1_now;
  logic [31:0] q;
  logic [31:0] mean_next;
  logic [31:0] d2;
  logic [64:0] m2_sum;
  logic [63:0] m2_next;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [31:0] mul_c;
  logic [63:0] prod;
  logic [31:0] factor;
  logic [WIDE_W-1:0] acc_next;
  logic        in_take;
  logic        out_load;
  logic [15:0] count_lo;

  div_req_t div_req;
  div_rsp_t div_rsp;

  asdd_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == ST_IDLE);
  assign in_take       = s_axis_tvalid && s_axis_tready;
  assign out_load      = (state == ST_OUT) && (!out_valid || m_axis_tready);

  assign n32     = 32'(count);
  assign count_lo = n32[15:0];
  assign ref_val = per_pixel ? running_mean : avg_luma;

  // Distance from the mean to the sample, and the moved mean once the
  // quotient is back. The mean never crosses the sample.
  assign mean_ge   = x >= running_mean ? 32'd1 : 32'd0;
  assign d1_now    = mean_ge[0] ? (x - running_mean) : (running_mean - x);
  assign q         = div_rsp.quotient[31:0];
  assign mean_next = ge ? (running_mean + q) : (running_mean - q);
  assign d2        = ge ? (x - running_mean) : (running_mean - x);

  // The sum of squared deviations sticks at all ones rather than wrapping.
  assign m2_sum  = {1'b0, m2} + {1'b0, inc};
  assign m2_next = m2_sum[64] ? {64{1'b1}} : m2_sum[63:0];

  // The confidence test is quantile^2 * M2 * 256 against
  // (max_error * ref)^2 * n * (n - 1), each side built one factor at a time.
  always_comb begin
    factor = '0;
    if (state == ST_MUL_LHS) begin
      unique case (fstep)
        3'd0, 3'd1: factor = 32'(quantile);
        default:    factor = 32'd256;
      endcase
    end else begin
      unique case (fstep)
        3'd0, 3'd2: factor = 32'(max_error);
        3'd1, 3'd3: factor = ref_val;
        3'd4:       factor = n32;
        default:    factor = n32 - 32'd1;
      endcase
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    mul_c = '0;
    if (state == ST_SQ) begin
      mul_a = d1;
      mul_b = d2;
    end else if (state == ST_MUL_LHS || state == ST_MUL_RHS) begin
      mul_a = acc[LIMB_W-1:0];
      mul_b = factor;
      mul_c = carry;
    end
  end

  assign prod     = mul_a * mul_b + 64'(mul_c);
  // The wide value rotates one limb per cycle past the multiplier.
  assign acc_next = {prod[LIMB_W-1:0], acc[WIDE_W-1:LIMB_W]};

  always_comb begin
    div_req = '0;
    if (state == ST_PREP) begin
      div_req.start    = 1'b1;
      div_req.steps    = DIV_STEP_W'(32);
      div_req.dividend = {d1_now, 32'd0};
      div_req.divisor  = n32;
    end else if (state == ST_ACC && n32 >= 32'd2) begin
      div_req.start    = 1'b1;
      div_req.steps    = DIV_STEP_W'(64);
      div_req.dividend = m2_next;
      div_req.divisor  = n32 - 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_samples  <= MIN_SAMPLES_RST;
      max_samples  <= MAX_SAMPLES_RST;
      limit_enable <= LIMIT_ENABLE_RST;
      max_error    <= MAX_ERROR_RST;
      quantile     <= QUANTILE_RST;
      per_pixel    <= PER_PIXEL_RST;
      avg_luma     <= AVG_LUMA_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MIN_SAMPLES:  min_samples  <= cfg_data[15:0];
        REG_MAX_SAMPLES:  max_samples  <= cfg_data[15:0];
        REG_LIMIT_ENABLE: limit_enable <= cfg_data[0];
        REG_MAX_ERROR:    max_error    <= cfg_data[15:0];
        REG_QUANTILE:     quantile     <= cfg_data[15:0];
        REG_PER_PIXEL:    per_pixel    <= cfg_data[0];
        REG_AVG_LUMA:     avg_luma     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer and statistics.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      running_mean <= '0;
      m2           <= '0;
      count        <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (out_valid && m_axis_tready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_take) begin
            if (s_axis_tuser[1]) begin
              running_mean <= '0;
              m2           <= '0;
              count        <= COUNT_BITS'(1);
            end else if (count != COUNT_MAX) begin
              count <= count + COUNT_BITS'(1);
            end
            state <= ST_PREP;
          end
        end
        ST_PREP: begin
          state <= ST_DIV_MEAN;
        end
        ST_DIV_MEAN: begin
          if (div_rsp.done) begin
            running_mean <= mean_next;
            state        <= ST_SQ;
          end
        end
        ST_SQ: begin
          state <= ST_ACC;
        end
        ST_ACC: begin
          m2 <= m2_next;
          if (n32 >= 32'd2) begin
            state <= ST_DIV_VAR;
          end else begin
            state <= ST_DECIDE;
          end
        end
        ST_DIV_VAR: begin
          if (div_rsp.done) begin
            state <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          if (limit_enable && n32 >= 32'(max_samples)) begin
            state <= ST_OUT;
          end else if (n32 >= 32'(min_samples)) begin
            state <= ST_MUL_LHS;
          end else begin
            state <= ST_OUT;
          end
        end
        ST_MUL_LHS: begin
          if (limb == 3'(NUM_LIMBS - 1) && fstep == 3'd2) begin
            state <= ST_MUL_RHS;
          end
        end
        ST_MUL_RHS: begin
          if (limb == 3'(NUM_LIMBS - 1) && fstep == 3'd5) begin
            state <= ST_CMP;
          end
        end
        ST_CMP: begin
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (out_load) begin
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Working values for the sample in flight.
  always_ff @(posedge clk) begin
    if (in_take) begin
      x <= s_axis_tuser[0] ? 32'(s_axis_tdata[LUMA_BITS-1:0]) : 32'd0;
    end
    if (state == ST_PREP) begin
      ge <= mean_ge[0];
      d1 <= d1_now;
    end
    if (state == ST_SQ) begin
      inc <= prod;
    end
    if (state == ST_ACC) begin
      variance <= '0;
    end
    if (state == ST_DIV_VAR && div_rsp.done) begin
      variance <= div_rsp.quotient;
    end
    if (state == ST_DECIDE) begin
      reason <= REASON_NONE;
      if (limit_enable && n32 >= 32'(max_samples)) begin
        reason <= REASON_LIMIT;
      end
      acc   <= WIDE_W'(m2);
      carry <= '0;
      limb  <= '0;
      fstep <= '0;
    end
    if (state == ST_MUL_LHS || state == ST_MUL_RHS) begin
      acc   <= acc_next;
      carry <= prod[63:LIMB_W];
      limb  <= limb + 3'd1;
      if (limb == 3'(NUM_LIMBS - 1)) begin
        // Carry out of the top limb is dropped; neither side can reach it.
        limb  <= '0;
        carry <= '0;
        fstep <= fstep + 3'd1;
        if (state == ST_MUL_LHS && fstep == 3'd2) begin
          lhs   <= acc_next;
          acc   <= WIDE_W'(1);
          fstep <= '0;
        end
      end
    end
    if (state == ST_CMP) begin
      reason <= (lhs <= acc) ? REASON_CONV : REASON_NONE;
    end
    if (out_load) begin
      out_data <= {5'd0, variance, running_mean, count_lo, reason,
                   (reason != REASON_NONE)};
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  // The divider is always idle when a new sample may be taken.
  a_div_idle_at_ready: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> !div_rsp.busy)
    else $error("divider busy while the unit is ready for a sample");

  // Once a sample is in flight the pixel has at least one sample.
  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> (count != '0))
    else $error("sample count is zero during processing");

  // The moved mean stays on the old mean's side of the sample.
  a_mean_bounded: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SQ) |-> (ge ? (running_mean <= x) : (running_mean >= x)))
    else $error("running mean overshot the sample");

  // A stop reason of limit can only follow the limit compare.
  a_limit_reason: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT && reason == REASON_LIMIT) |->
      (limit_enable && n32 >= 32'(max_samples)))
    else $error("limit reason without the sample limit reached");

endmodule

@@ sv/asdd_div.sv @@
module asdd_div (
  input  logic                clk,
  input  logic                rst,
  input  asdd_pkg::div_req_t  req,
  output asdd_pkg::div_rsp_t  rsp
);
  import asdd_pkg::*;

  logic                  busy;
  logic                  done;
  logic [DIV_STEP_W-1:0] cnt;
  logic [DIV_DVD_W-1:0]  dvd;
  logic [DIV_DVD_W-1:0]  quo;
  logic [DIV_DSR_W-1:0]  rem;
  logic [DIV_DSR_W-1:0]  dsr;
  logic [DIV_DSR_W:0]    trial;
  logic [DIV_DSR_W:0]    diff;
  logic                  fits;

  // One quotient bit per cycle, taken from the top of the shifting dividend.
  assign trial = {rem, dvd[DIV_DVD_W-1]};
  assign diff  = trial - {1'b0, dsr};
  assign fits  = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.steps;
      end else if (busy) begin
        cnt <= cnt - DIV_STEP_W'(1);
        if (cnt == DIV_STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd <= req.dividend;
      dsr <= req.divisor;
      rem <= '0;
      quo <= '0;
    end else if (busy) begin
      rem <= fits ? diff[DIV_DSR_W-1:0] : trial[DIV_DSR_W-1:0];
      dvd <= {dvd[DIV_DVD_W-2:0], 1'b0};
      quo <= {quo[DIV_DVD_W-2:0], fits};
    end
  end

  assign rsp.busy     = busy;
  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

@@ tb/tb_adaptive_sample_stop_decider_unit.sv @@
`timescale 1ns / 100ps

module tb_adaptive_sample_stop_decider_unit;
  import asdd_pkg::*;

  // Rough total of sample words: the directed table plus the random phases.
  localparam int ITEM_TARGET = 1750;
  // Time allowed to run on after the last result has been taken.
  localparam int DRAIN_CYCLES = 200;

  // One result word after unpacking from m_axis_tdata.
  typedef struct packed {
    logic        done;
    reason_t     reason;
    logic [15:0] cnt;
    logic [31:0] mean;
    logic [63:0] variance;
  } result_t;

  typedef enum logic {
    ROW_CFG,
    ROW_SAMPLE
  } row_kind_t;

  // One row of the directed table: either a register write or a sample word.
  // Where typed is set, the expected result is given by hand in res.
  typedef struct {
    row_kind_t   kind;
    cfg_index_t  idx;
    logic [31:0] val;
    logic [31:0] lum;
    logic        acc;
    logic        first;
    logic        typed;
    result_t     res;
  } row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [IN_USER_W-1:0]  s_axis_tuser = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  cfg_index_t            cfg_index = REG_MIN_SAMPLES;
  logic [31:0]           cfg_data = '0;

  // The testbench's own copy of the pixel statistics and the registers.
  logic [31:0] acc_mean;
  logic [63:0] acc_m2;
  logic [15:0] acc_count;
  logic [15:0] cur_min_samples;
  logic [15:0] cur_max_samples;
  logic        cur_limit_en;
  logic [15:0] cur_max_error;
  logic [15:0] cur_quantile;
  logic        cur_per_pixel;
  logic [31:0] cur_avg_luma;

  result_t pending_results[$];
  row_t    plan[$];
  int      error_count = 0;
  int      items_sent = 0;
  bit      tx_idle_en = 1'b1;
  bit      rx_idle_en = 1'b1;
  int      rx_gap = 0;

  adaptive_sample_stop_decider_unit DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Welford update of one sample followed by the stop decision. The confidence
  // test is kept in squared form: quantile^2 * M2 * 256 on the left (the 256
  // brings the Q4.12 squared quantile up to the scale of the right-hand side)
  // against (max_error * ref)^2 * n * (n - 1). Both sides fit well within 160
  // bits, so nothing wraps.
  function automatic result_t welford_step(input logic [31:0] lum, input logic acc,
                                           input logic first);
    result_t      r;
    logic [31:0]  x;
    logic [31:0]  old_mean;
    logic [31:0]  ref_luma;
    logic [63:0]  d1;
    logic [63:0]  d2;
    logic [63:0]  prod;
    logic [64:0]  sum_wide;
    logic [159:0] lhs;
    logic [159:0] rhs;
    x = acc ? lum : 32'd0;
    if (first) begin
      acc_mean  = '0;
      acc_m2    = '0;
      acc_count = '0;
    end
    // The count sticks at its top value rather than wrapping.
    if (acc_count != 16'hFFFF) begin
      acc_count = acc_count + 16'd1;
    end
    old_mean = acc_mean;
    // The mean steps towards the sample by a truncated share, so both
    // deviations have the same sign and their product is never negative.
    if (x >= old_mean) begin
      d1       = 64'(x - old_mean);
      acc_mean = old_mean + 32'(d1 / 64'(acc_count));
      d2       = 64'(x - acc_mean);
    end else begin
      d1       = 64'(old_mean - x);
      acc_mean = old_mean - 32'(d1 / 64'(acc_count));
      d2       = 64'(acc_mean - x);
    end
    prod     = d1 * d2;
    sum_wide = {1'b0, acc_m2} + {1'b0, prod};
    acc_m2   = sum_wide[64] ? 64'hFFFF_FFFF_FFFF_FFFF : sum_wide[63:0];
    r.cnt      = acc_count;
    r.mean     = acc_mean;
    r.variance = (acc_count >= 16'd2) ? acc_m2 / 64'(acc_count - 16'd1) : 64'd0;
    r.reason   = REASON_NONE;
    // The sample limit takes precedence over the confidence test.
    if (cur_limit_en && acc_count >= cur_max_samples) begin
      r.reason = REASON_LIMIT;
    end else if (acc_count >= cur_min_samples) begin
      ref_luma = cur_per_pixel ? acc_mean : cur_avg_luma;
      lhs = 160'(acc_m2) * 160'(cur_quantile) * 160'(cur_quantile) * 160'd256;
      rhs = 160'(cur_max_error) * 160'(ref_luma) * 160'(cur_max_error) * 160'(ref_luma)
            * 160'(acc_count) * 160'(acc_count - 16'd1);
      if (lhs <= rhs) begin
        r.reason = REASON_CONV;
      end
    end
    r.done = (r.reason != REASON_NONE);
    return r;
  endfunction

  task automatic add_cfg(input cfg_index_t idx, input logic [31:0] val);
    row_t row;
    row = '{kind: ROW_CFG, idx: idx, val: val, lum: '0, acc: 1'b0, first: 1'b0,
            typed: 1'b0, res: '0};
    plan.push_back(row);
  endtask

  task automatic add_sample(input logic [31:0] lum, input logic acc, input logic first);
    row_t row;
    row = '{kind: ROW_SAMPLE, idx: REG_MIN_SAMPLES, val: '0, lum: lum, acc: acc,
            first: first, typed: 1'b0, res: '0};
    plan.push_back(row);
  endtask

  task automatic add_checked(input logic [31:0] lum, input logic acc, input logic first,
                             input logic done, input reason_t reason, input logic [15:0] cnt,
                             input logic [31:0] mean, input logic [63:0] variance);
    row_t row;
    row = '{kind: ROW_SAMPLE, idx: REG_MIN_SAMPLES, val: '0, lum: lum, acc: acc,
            first: first, typed: 1'b1, res: '{done, reason, cnt, mean, variance}};
    plan.push_back(row);
  endtask

  // Lowers tvalid and holds off until every outstanding result has been taken.
  // As each sample word gives exactly one result, the unit is idle after that.
  task automatic wait_drain();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [31:0] val);
    wait_drain();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_MIN_SAMPLES:  cur_min_samples = val[15:0];
      REG_MAX_SAMPLES:  cur_max_samples = val[15:0];
      REG_LIMIT_ENABLE: cur_limit_en    = val[0];
      REG_MAX_ERROR:    cur_max_error   = val[15:0];
      REG_QUANTILE:     cur_quantile    = val[15:0];
      REG_PER_PIXEL:    cur_per_pixel   = val[0];
      REG_AVG_LUMA:     cur_avg_luma    = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Presents one sample word after a random gap and returns the predicted
  // result at the edge where the word is taken. tvalid is left high so that a
  // back-to-back word needs no second assignment in the same time step.
  task automatic send_sample(input logic [31:0] lum, input logic acc, input logic first,
                             output result_t pred);
    int gap;
    gap = tx_idle_en ? int'($urandom_range(0, 3)) : 0;
    if (gap > 0) begin
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_axis_tdata  <= lum;
    s_axis_tuser  <= {first, acc};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    pred = welford_step(lum, acc, first);
    items_sent++;
  endtask

  function automatic void report_field(input string name, input logic [63:0] exp_val,
                                       input logic [63:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_val, act_val);
      error_count++;
    end
  endfunction

  // Result side: tready drops for a random number of cycles after each word,
  // and every word taken is compared field by field with the oldest expectation.
  initial begin : result_sink
    result_t got;
    result_t want;
    forever begin
      @(negedge clk);
      m_axis_tready <= !rst && (rx_gap == 0);
      if (rx_gap > 0) begin
        rx_gap--;
      end
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready) begin
        got.done     = m_axis_tdata[0];
        got.reason   = reason_t'(m_axis_tdata[2:1]);
        got.cnt      = m_axis_tdata[18:3];
        got.mean     = m_axis_tdata[50:19];
        got.variance = m_axis_tdata[114:51];
        if (pending_results.size() == 0) begin
          $display("%0t: result word with nothing pending, actual %h", $time, m_axis_tdata);
          error_count++;
        end else begin
          want = pending_results.pop_front();
          report_field("done_res", 64'(want.done), 64'(got.done));
          report_field("stop_reason", 64'(want.reason), 64'(got.reason));
          report_field("sample_count", 64'(want.cnt), 64'(got.cnt));
          report_field("mean_out", 64'(want.mean), 64'(got.mean));
          report_field("variance_out", want.variance, got.variance);
        end
        rx_gap = rx_idle_en ? int'($urandom_range(0, 3)) : 0;
      end
    end
  end

  initial begin : stimulus
    result_t     pred;
    logic [31:0] base;
    logic [31:0] lum;
    logic        acc;
    logic        first;
    logic        new_pixel;
    int          shift;
    int          pixel_len;
    int          phase_end;

    acc_mean        = '0;
    acc_m2          = '0;
    acc_count       = '0;
    cur_min_samples = MIN_SAMPLES_RST;
    cur_max_samples = MAX_SAMPLES_RST;
    cur_limit_en    = LIMIT_ENABLE_RST;
    cur_max_error   = MAX_ERROR_RST;
    cur_quantile    = QUANTILE_RST;
    cur_per_pixel   = PER_PIXEL_RST;
    cur_avg_luma    = AVG_LUMA_RST;

    // Register defaults after reset, then a rejected sample counting as zero.
    add_checked(32'h0001_0000, 1'b1, 1'b1, 1'b0, REASON_NONE, 16'd1, 32'h0001_0000, 64'd0);
    add_sample(32'h0003_0000, 1'b1, 1'b0);
    add_sample(32'hFFFF_FFFF, 1'b0, 1'b0);
    add_checked(32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0, REASON_NONE, 16'd1, 32'd0, 64'd0);
    // A zero sample limit stops every word.
    add_cfg(REG_MAX_SAMPLES, 32'd0);
    add_checked(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, REASON_LIMIT, 16'd1, 32'hFFFF_FFFF, 64'd0);
    // Alternating full-scale samples drive M2 into saturation within a few
    // words; the pixel carries on accumulating after the limit is reached.
    add_cfg(REG_MAX_SAMPLES, 32'd3);
    add_sample(32'd0, 1'b1, 1'b0);
    add_sample(32'hFFFF_FFFF, 1'b1, 1'b0);
    add_sample(32'd0, 1'b1, 1'b0);
    add_sample(32'hFFFF_FFFF, 1'b1, 1'b0);
    add_sample(32'd0, 1'b1, 1'b0);
    add_cfg(REG_LIMIT_ENABLE, 32'd0);
    add_sample(32'hFFFF_FFFF, 1'b1, 1'b0);
    // A minimum below two lets the test run on the first sample, where both
    // sides are zero, so the pixel converges at once.
    add_cfg(REG_MIN_SAMPLES, 32'd0);
    add_checked(32'h1234_5678, 1'b1, 1'b1, 1'b1, REASON_CONV, 16'd1, 32'h1234_5678, 64'd0);
    add_cfg(REG_MIN_SAMPLES, 32'd1);
    add_checked(32'h0000_0001, 1'b1, 1'b1, 1'b1, REASON_CONV, 16'd1, 32'h0000_0001, 64'd0);
    // Zero reference: only a zero M2 or a zero quantile passes.
    add_cfg(REG_AVG_LUMA, 32'd0);
    add_cfg(REG_MIN_SAMPLES, 32'd2);
    add_sample(32'h0001_0000, 1'b1, 1'b1);
    add_sample(32'h0001_0000, 1'b1, 1'b0);
    add_sample(32'h0002_0000, 1'b1, 1'b0);
    add_cfg(REG_QUANTILE, 32'd0);
    add_sample(32'h0003_0000, 1'b1, 1'b0);
    // Zero error allowance against a full-scale reference.
    add_cfg(REG_QUANTILE, 32'h0000_FFFF);
    add_cfg(REG_MAX_ERROR, 32'd0);
    add_cfg(REG_AVG_LUMA, 32'hFFFF_FFFF);
    add_sample(32'h0000_0005, 1'b1, 1'b1);
    add_sample(32'h0000_0007, 1'b1, 1'b0);
    // Largest error allowance, measured against the pixel's own mean.
    add_cfg(REG_MAX_ERROR, 32'h0000_FFFF);
    add_cfg(REG_PER_PIXEL, 32'd1);
    add_sample(32'h0001_0000, 1'b1, 1'b1);
    add_sample(32'h0001_0001, 1'b1, 1'b0);
    add_sample(32'h0001_0000, 1'b1, 1'b0);
    // Top of the range for both sample counts.
    add_cfg(REG_MIN_SAMPLES, 32'h0000_FFFF);
    add_cfg(REG_MAX_SAMPLES, 32'h0000_FFFF);
    add_cfg(REG_LIMIT_ENABLE, 32'd1);
    add_cfg(REG_PER_PIXEL, 32'd0);
    add_checked(32'h0001_0000, 1'b1, 1'b1, 1'b0, REASON_NONE, 16'd1, 32'h0001_0000, 64'd0);
    add_sample(32'h0002_0000, 1'b1, 1'b0);

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        write_reg(plan[i].idx, plan[i].val);
      end else begin
        send_sample(plan[i].lum, plan[i].acc, plan[i].first, pred);
        pending_results.push_back(plan[i].typed ? plan[i].res : pred);
      end
    end

    // Random phases. Each one rewrites every register once the unit is idle,
    // then feeds pixels of noisy samples at and above a random level. A pixel mostly
    // ends when its stop decision comes; now and then a stray word with random
    // flags breaks into the sequence.
    while (items_sent < ITEM_TARGET) begin
      tx_idle_en = ($urandom_range(0, 3) != 0);
      rx_idle_en = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 9))
        0:       write_reg(REG_MIN_SAMPLES, 32'd0);
        1:       write_reg(REG_MIN_SAMPLES, 32'd1);
        2:       write_reg(REG_MIN_SAMPLES, 32'h0000_FFFF);
        default: write_reg(REG_MIN_SAMPLES, $urandom_range(2, 40));
      endcase
      case ($urandom_range(0, 9))
        0:       write_reg(REG_MAX_SAMPLES, 32'd0);
        1:       write_reg(REG_MAX_SAMPLES, 32'd1);
        2:       write_reg(REG_MAX_SAMPLES, 32'h0000_FFFF);
        default: write_reg(REG_MAX_SAMPLES, $urandom_range(2, 80));
      endcase
      write_reg(REG_LIMIT_ENABLE, $urandom_range(0, 1));
      case ($urandom_range(0, 9))
        0:       write_reg(REG_MAX_ERROR, 32'd0);
        1:       write_reg(REG_MAX_ERROR, 32'h0000_FFFF);
        default: write_reg(REG_MAX_ERROR, $urandom_range(300, 20000));
      endcase
      case ($urandom_range(0, 9))
        0:       write_reg(REG_QUANTILE, 32'd0);
        1:       write_reg(REG_QUANTILE, 32'h0000_FFFF);
        default: write_reg(REG_QUANTILE, $urandom_range(4000, 12000));
      endcase
      write_reg(REG_PER_PIXEL, $urandom_range(0, 1));
      case ($urandom_range(0, 9))
        0:       write_reg(REG_AVG_LUMA, 32'd0);
        1:       write_reg(REG_AVG_LUMA, 32'hFFFF_FFFF);
        2:       write_reg(REG_AVG_LUMA, $urandom());
        default: write_reg(REG_AVG_LUMA, $urandom_range(32'h0000_8000, 32'h0004_0000));
      endcase

      phase_end = items_sent + int'($urandom_range(80, 200));
      new_pixel = 1'b1;
      base      = '0;
      shift     = 1;
      pixel_len = 0;
      while (items_sent < phase_end && items_sent < ITEM_TARGET) begin
        if (new_pixel) begin
          // Occasionally the sender holds back until the unit has drained.
          if ($urandom_range(0, 9) == 0) begin
            wait_drain();
          end
          case ($urandom_range(0, 5))
            0:       base = $urandom();
            1:       base = $urandom_range(0, 32'h000F_FFFF);
            default: base = $urandom_range(32'h0000_4000, 32'h0004_0000);
          endcase
          shift     = $urandom_range(1, 14);
          pixel_len = 0;
        end
        if ($urandom_range(0, 15) == 0) begin
          lum   = $urandom();
          acc   = 1'($urandom_range(0, 1));
          first = 1'($urandom_range(0, 1));
        end else begin
          lum   = base + $urandom_range(0, base >> shift);
          acc   = ($urandom_range(0, 19) != 0);
          first = new_pixel;
        end
        send_sample(lum, acc, first, pred);
        pending_results.push_back(pred);
        pixel_len++;
        new_pixel = (pred.done && $urandom_range(0, 7) != 0) || pixel_len >= 400;
      end
    end

    wait_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Declares the run hung if it has not finished when this timer runs out.
  initial begin : watchdog
    #4000000;
    $display("status: fail");
    $finish;
  end

endmodule

@@ sim.f @@
sv/asdd_pkg.sv
sv/asdd_div.sv
sv/adaptive_sample_stop_decider_unit.sv
tb/tb_adaptive_sample_stop_decider_unit.sv
